/* sv/bvm_pkg.sv */
// Shared types, constants and discharge-curve table for the battery voltage monitor.
package bvm_pkg;

  localparam int BVM_OVERSAMPLE = 16;
  localparam int CURVE_POINTS   = 12;
  localparam int CURVE_IDX_W    = $clog2(CURVE_POINTS);

  localparam int TIME_W   = 32;
  localparam int PIN_W    = 12;
  localparam int CELL_W   = 13;
  localparam int MARGIN_W = 10;
  localparam int PCT_W    = 7;
  localparam int PROD_W   = CELL_W + PCT_W;
  localparam int DEN_W    = CELL_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [TIME_W-1:0] RST_INTERVAL   = 32'd5000;
  localparam logic [CELL_W-1:0] RST_PLAUS_MIN  = 13'd2500;
  localparam logic [CELL_W-1:0] RST_PLAUS_MAX  = 13'd4400;
  localparam logic [CELL_W-1:0] RST_LOW_THR    = 13'd3400;
  localparam logic [MARGIN_W-1:0] RST_REARM    = 10'd100;

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // register index codes (byte address / 4)
  localparam logic [2:0] REG_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_PLAUS_MIN = 3'd1;
  localparam logic [2:0] REG_PLAUS_MAX = 3'd2;
  localparam logic [2:0] REG_LOW_THR   = 3'd3;
  localparam logic [2:0] REG_REARM     = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0]   sample_interval_ms;
    logic [CELL_W-1:0]   plausible_min_mv;
    logic [CELL_W-1:0]   plausible_max_mv;
    logic [CELL_W-1:0]   low_threshold_mv;
    logic [MARGIN_W-1:0] rearm_margin_mv;
  } cfg_t;

  typedef struct packed {
    logic acc;        // sample beat taken
    logic div_start;  // launch interpolation divide
    logic cell_load;  // capture average
    logic seg;        // window check and curve segment lookup
    logic mul;        // interpolation product
    logic finish;     // result to output register
  } cmd_t;

  typedef struct packed {
    logic round_last;
    logic div_done;
    logic direct;
    logic out_free;
  } stat_t;

  function automatic logic [CELL_W-1:0] curve_mv(input logic [CURVE_IDX_W-1:0] idx);
    logic [CELL_W-1:0] v;
    case (idx)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4100;
      4'd2:    v = 13'd4000;
      4'd3:    v = 13'd3950;
      4'd4:    v = 13'd3870;
      4'd5:    v = 13'd3820;
      4'd6:    v = 13'd3790;
      4'd7:    v = 13'd3770;
      4'd8:    v = 13'd3740;
      4'd9:    v = 13'd3680;
      4'd10:   v = 13'd3450;
      4'd11:   v = 13'd3000;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [CURVE_IDX_W-1:0] idx);
    logic [PCT_W-1:0] v;
    case (idx)
      4'd0:    v = 7'd100;
      4'd1:    v = 7'd90;
      4'd2:    v = 7'd80;
      4'd3:    v = 7'd70;
      4'd4:    v = 7'd60;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd40;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd20;
      4'd9:    v = 7'd10;
      4'd10:   v = 7'd5;
      4'd11:   v = 7'd0;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/bvm_div.sv */
// Restoring divider, one quotient bit per cycle.
module bvm_div #(
  parameter int NUM_W = 20,
  parameter int DW    = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;
  logic             ge;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= CNT_W'(NUM_W);
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo  <= {quo[NUM_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

/* sv/bvm_datapath.sv */
// Datapath: round accumulation, divider, window check, curve interpolation, result register.
module bvm_datapath #(
  parameter int OVERSAMPLE = bvm_pkg::BVM_OVERSAMPLE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bvm_pkg::cfg_t                 cfg,
  input  bvm_pkg::cmd_t                 cmd,
  output bvm_pkg::stat_t                stat,
  input  logic [bvm_pkg::TIME_W-1:0]    now_ms,
  input  logic [bvm_pkg::PIN_W-1:0]     pin_mv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bvm_pkg::CELL_W-1:0]    cell_mv,
  output logic                          plausible,
  output logic [bvm_pkg::PCT_W-1:0]     percent,
  output logic                          low_event
);

  import bvm_pkg::*;

  localparam int SUM_W = $clog2((2 ** PIN_W - 1) * OVERSAMPLE + 1);
  localparam int CNT_W = $clog2(OVERSAMPLE + 1);

  // average by reciprocal multiply: exact floor for every sum below 2^SUM_W
  localparam int AVG_SH  = SUM_W + $clog2(OVERSAMPLE);
  localparam int RECIP_W = SUM_W + 1;
  localparam int AVG_PW  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << AVG_SH) + 64'(OVERSAMPLE) - 64'd1) / 64'(OVERSAMPLE));

  // round state
  logic [TIME_W-1:0] round_start_ms;
  logic              in_round;
  logic [CNT_W-1:0]  samples_taken;
  logic [SUM_W-1:0]  sample_sum;
  logic              warning_latched;

  logic [TIME_W-1:0] elapsed;
  logic              open_round;
  logic              take;
  logic [CNT_W-1:0]  cnt_next;
  logic [SUM_W-1:0]  sum_next;
  logic              last;

  assign elapsed    = now_ms - round_start_ms;
  assign open_round = !in_round && (elapsed >= cfg.sample_interval_ms);
  assign take       = in_round || open_round;
  assign cnt_next   = (open_round ? '0 : samples_taken) + 1'b1;
  assign sum_next   = (open_round ? '0 : sample_sum) + SUM_W'(pin_mv);
  assign last       = take && (cnt_next == CNT_W'(OVERSAMPLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      round_start_ms <= '0;
      in_round       <= 1'b0;
      samples_taken  <= '0;
      sample_sum     <= '0;
    end else if (cmd.acc && take) begin
      if (open_round) begin
        round_start_ms <= now_ms;
      end
      sample_sum    <= sum_next;
      samples_taken <= last ? '0 : cnt_next;
      in_round      <= !last;
    end
  end

  // average
  logic [AVG_PW-1:0] avg_prod;

  assign avg_prod = AVG_PW'(sample_sum) * AVG_PW'(RECIP);

  // interpolation divider
  logic [PROD_W-1:0] div_quo;
  logic              div_done;
  logic [PROD_W-1:0] product;
  logic [CELL_W-1:0] span;

  bvm_div #(
    .NUM_W(PROD_W),
    .DW   (DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (product),
    .den  (span),
    .quo  (div_quo),
    .done (div_done)
  );

  // window check and segment lookup
  logic [CELL_W-1:0] cell_val;
  logic              ok;
  logic              direct;
  logic [PCT_W-1:0]  direct_pct;
  logic [CELL_W-1:0] hi_mv;
  logic [CELL_W-1:0] lo_mv;
  logic [PCT_W-1:0]  hi_pct;
  logic [PCT_W-1:0]  lo_pct;

  logic              ok_c;
  logic              found;
  logic [CURVE_IDX_W-1:0] seg_k;
  logic [CELL_W-1:0] seg_hi_mv;
  logic [CELL_W-1:0] seg_lo_mv;

  always_comb begin
    found = 1'b0;
    seg_k = CURVE_IDX_W'(CURVE_POINTS - 1);
    for (int k = 1; k < CURVE_POINTS; k++) begin
      if (!found && (cell_val >= curve_mv(CURVE_IDX_W'(k)))) begin
        found = 1'b1;
        seg_k = CURVE_IDX_W'(k);
      end
    end
  end

  assign ok_c      = (cell_val >= cfg.plausible_min_mv) && (cell_val <= cfg.plausible_max_mv);
  assign seg_hi_mv = curve_mv(seg_k - 1'b1);
  assign seg_lo_mv = curve_mv(seg_k);

  always_ff @(posedge clk) begin
    if (cmd.cell_load) begin
      cell_val <= {avg_prod[AVG_SH +: PIN_W], 1'b0};
    end
    if (cmd.seg) begin
      ok     <= ok_c;
      hi_mv  <= seg_hi_mv;
      lo_mv  <= seg_lo_mv;
      hi_pct <= curve_pct(seg_k - 1'b1);
      lo_pct <= curve_pct(seg_k);
      direct <= 1'b1;
      if (!ok_c || cell_val == '0) begin
        direct_pct <= PCT_EMPTY;
      end else if (cell_val >= curve_mv('0)) begin
        direct_pct <= PCT_FULL;
      end else if (cell_val <= curve_mv(CURVE_IDX_W'(CURVE_POINTS - 1))) begin
        direct_pct <= PCT_EMPTY;
      end else if (seg_hi_mv <= seg_lo_mv) begin
        direct_pct <= curve_pct(seg_k);
      end else begin
        direct     <= 1'b0;
        direct_pct <= PCT_EMPTY;
      end
    end
    if (cmd.mul) begin
      product <= PROD_W'(cell_val - lo_mv) *
                 PROD_W'((hi_pct >= lo_pct) ? (hi_pct - lo_pct) : PCT_EMPTY);
      span    <= hi_mv - lo_mv;
    end
  end

  // result register and low warning
  logic [PCT_W-1:0]  pct;
  logic [CELL_W:0]   rearm_level;
  logic              out_free;

  assign pct         = direct ? direct_pct : lo_pct + div_quo[PCT_W-1:0];
  assign rearm_level = {1'b0, cfg.low_threshold_mv} + (CELL_W + 1)'(cfg.rearm_margin_mv);
  assign out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      warning_latched <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      cell_mv   <= ok ? cell_val : '0;
      plausible <= ok;
      percent   <= ok ? pct : PCT_EMPTY;
      low_event <= ok && (cell_val < cfg.low_threshold_mv) && !warning_latched;
      if (!ok) begin
        warning_latched <= 1'b0;
      end else if (cell_val < cfg.low_threshold_mv) begin
        warning_latched <= 1'b1;
      end else if ({1'b0, cell_val} > rearm_level) begin
        warning_latched <= 1'b0;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.round_last = last;
  assign stat.div_done   = div_done;
  assign stat.direct     = direct;
  assign stat.out_free   = out_free;

endmodule

/* sv/bvm_ctrl.sv */
// Controller: sequences accumulation, averaging, curve lookup, interpolation divide and result load.
module bvm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bvm_pkg::stat_t stat,
  output bvm_pkg::cmd_t  cmd
);

  import bvm_pkg::*;

  typedef enum logic [2:0] {
    IDLE, AVG, SEG, MUL, PCT_GO, PCT_WAIT, FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:     if (in_valid && stat.round_last) state <= AVG;
        AVG:      state <= SEG;
        SEG:      state <= MUL;
        MUL:      state <= stat.direct ? FINISH : PCT_GO;
        PCT_GO:   state <= PCT_WAIT;
        PCT_WAIT: if (stat.div_done) state <= FINISH;
        FINISH:   if (stat.out_free) state <= IDLE;
        default:  state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.acc       = (state == IDLE) && in_valid;
    cmd.div_start = (state == PCT_GO);
    cmd.cell_load = (state == AVG);
    cmd.seg       = (state == SEG);
    cmd.mul       = (state == MUL) && !stat.direct;
    cmd.finish    = (state == FINISH) && stat.out_free;
  end

  assign in_stall = (state != IDLE);

endmodule

/* sv/battery_voltage_monitor_top.sv */
// Top level of the battery voltage monitor: register port, controller and datapath.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   now_ms, pin_mv
//   out      source     out_valid/out_stall cell_mv, plausible, percent, low_event
//   apb      slave      psel/penable/pready paddr, pwdata, prdata
//
// After the beat that closes a round, in_stall stays high through the average, segment
// lookup and product steps, then a serial divide of one bit per cycle; the product and
// divide are skipped when no interpolation is needed.
// in_stall is high from the closing beat until the result enters the output register.
// A waiting result holds under out_stall; sampling resumes behind it.
// Synchronous reset restores register defaults and clears round state and warning latch.
module battery_voltage_monitor_top #(
  parameter int OVERSAMPLE = bvm_pkg::BVM_OVERSAMPLE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bvm_pkg::ADDR_W-1:0]   paddr,
  input  logic [bvm_pkg::DATA_W-1:0]   pwdata,
  output logic [bvm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bvm_pkg::TIME_W-1:0]   now_ms,
  input  logic [bvm_pkg::PIN_W-1:0]    pin_mv,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bvm_pkg::CELL_W-1:0]   cell_mv,
  output logic                         plausible,
  output logic [bvm_pkg::PCT_W-1:0]    percent,
  output logic                         low_event
);

  import bvm_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ms <= RST_INTERVAL;
      cfg.plausible_min_mv   <= RST_PLAUS_MIN;
      cfg.plausible_max_mv   <= RST_PLAUS_MAX;
      cfg.low_threshold_mv   <= RST_LOW_THR;
      cfg.rearm_margin_mv    <= RST_REARM;
    end else if (wr) begin
      case (paddr[4:2])
        REG_INTERVAL:  cfg.sample_interval_ms <= pwdata[TIME_W-1:0];
        REG_PLAUS_MIN: cfg.plausible_min_mv   <= pwdata[CELL_W-1:0];
        REG_PLAUS_MAX: cfg.plausible_max_mv   <= pwdata[CELL_W-1:0];
        REG_LOW_THR:   cfg.low_threshold_mv   <= pwdata[CELL_W-1:0];
        REG_REARM:     cfg.rearm_margin_mv    <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_INTERVAL:  prdata = DATA_W'(cfg.sample_interval_ms);
      REG_PLAUS_MIN: prdata = DATA_W'(cfg.plausible_min_mv);
      REG_PLAUS_MAX: prdata = DATA_W'(cfg.plausible_max_mv);
      REG_LOW_THR:   prdata = DATA_W'(cfg.low_threshold_mv);
      REG_REARM:     prdata = DATA_W'(cfg.rearm_margin_mv);
      default:       prdata = '0;
    endcase
  end

  bvm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  bvm_datapath #(
    .OVERSAMPLE(OVERSAMPLE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .now_ms   (now_ms),
    .pin_mv   (pin_mv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_mv  (cell_mv),
    .plausible(plausible),
    .percent  (percent),
    .low_event(low_event)
  );

endmodule

/* sv/bvm_checker.sv */
// Port-level assertions for the battery voltage monitor, bound to the top level.
module bvm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bvm_pkg::CELL_W-1:0] cell_mv,
  input logic                       plausible,
  input logic [bvm_pkg::PCT_W-1:0]  percent,
  input logic                       low_event
);

  import bvm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(cell_mv) && $stable(percent) && $stable(low_event))
    else $error("stalled result beat changed");

  a_implausible: assert property (@(posedge clk) disable iff (rst)
    out_valid && !plausible |-> cell_mv == '0 && percent == '0 && !low_event)
    else $error("implausible result carries nonzero fields");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> percent <= PCT_FULL)
    else $error("percent above full scale");

endmodule

bind battery_voltage_monitor_top bvm_checker u_bvm_checker (.*);

/* tb/sv/tb_battery_voltage_monitor_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the battery voltage monitor: round-based stimulus, fuel gauge scoreboard.
module tb_battery_voltage_monitor_top;
  import bvm_pkg::*;

  localparam logic [2:0] REG_SPARE    = 3'd7;
  localparam int         PHASE_ITEMS  = 204;
  localparam int         SETTLE_CYC   = 64;
  localparam int         QUIET_LIMIT  = 20000;
  localparam int unsigned KNEE_MV [12] = '{4200, 4100, 4000, 3950, 3870, 3820,
                                          3790, 3770, 3740, 3680, 3450, 3000};
  localparam int unsigned KNEE_PCT [12] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 0};

  typedef struct {
    logic [CELL_W-1:0] cell_mv;
    logic              plausible;
    logic [PCT_W-1:0]  percent;
    logic              low_event;
  } reading_t;

  class gauge_scoreboard;
    logic [TIME_W-1:0]   interval;
    logic [CELL_W-1:0]   win_min;
    logic [CELL_W-1:0]   win_max;
    logic [CELL_W-1:0]   low_thr;
    logic [MARGIN_W-1:0] margin;
    logic [TIME_W-1:0]   round_start;
    bit                  in_round;
    int unsigned         taken;
    int unsigned         sum;
    bit                  latched;
    reading_t            pending[$];
    int                  errors;
    int unsigned         used;

    function new();
      interval    = RST_INTERVAL;
      win_min     = RST_PLAUS_MIN;
      win_max     = RST_PLAUS_MAX;
      low_thr     = RST_LOW_THR;
      margin      = RST_REARM;
      round_start = '0;
      in_round    = 0;
      taken       = 0;
      sum         = 0;
      latched     = 0;
      errors      = 0;
      used        = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_INTERVAL:  interval = v;
        REG_PLAUS_MIN: win_min  = v[CELL_W-1:0];
        REG_PLAUS_MAX: win_max  = v[CELL_W-1:0];
        REG_LOW_THR:   low_thr  = v[CELL_W-1:0];
        REG_REARM:     margin   = v[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned soc_percent(int unsigned mv);
      int k;
      if (mv == 0 || mv <= KNEE_MV[11]) return 0;
      if (mv >= KNEE_MV[0]) return 100;
      for (k = 1; k < 12; k++) begin
        if (mv >= KNEE_MV[k]) begin
          return KNEE_PCT[k] + ((mv - KNEE_MV[k]) * (KNEE_PCT[k-1] - KNEE_PCT[k])) /
                 (KNEE_MV[k-1] - KNEE_MV[k]);
        end
      end
      return 0;
    endfunction

    // one accepted sample beat; queues a reading when it closes a round
    function void take_sample(logic [TIME_W-1:0] now, logic [PIN_W-1:0] pin);
      logic [TIME_W-1:0] since;
      int unsigned       cell_val;
      bit                ok;
      bit                ev;
      reading_t          r;
      since = now - round_start;
      if (!in_round) begin
        if (since < interval) return;
        round_start = now;
        in_round    = 1;
        taken       = 0;
        sum         = 0;
      end
      used++;
      sum += pin;
      taken++;
      if (taken < BVM_OVERSAMPLE) return;
      cell_val = (sum / BVM_OVERSAMPLE) * 2;
      in_round = 0;
      taken    = 0;
      sum      = 0;
      ok = (cell_val >= win_min) && (cell_val <= win_max);
      ev = 0;
      if (!ok) begin
        latched = 0;
      end else if (cell_val < low_thr) begin
        if (!latched) begin
          latched = 1;
          ev      = 1;
        end
      end else if (cell_val > low_thr + margin) begin
        latched = 0;
      end
      r.cell_mv   = ok ? CELL_W'(cell_val) : '0;
      r.plausible = ok;
      r.percent   = ok ? PCT_W'(soc_percent(cell_val)) : '0;
      r.low_event = ev;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected reading cell_mv=%0d", got.cell_mv));
        return;
      end
      want = pending.pop_front();
      if (got.cell_mv !== want.cell_mv)
        report($sformatf("cell_mv got %0d want %0d", got.cell_mv, want.cell_mv));
      if (got.plausible !== want.plausible)
        report($sformatf("plausible got %0b want %0b", got.plausible, want.plausible));
      if (got.percent !== want.percent)
        report($sformatf("percent got %0d want %0d", got.percent, want.percent));
      if (got.low_event !== want.low_event)
        report($sformatf("low_event got %0b want %0b", got.low_event, want.low_event));
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] now_ms    = '0;
  logic [PIN_W-1:0]  pin_mv    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CELL_W-1:0] cell_mv;
  logic              plausible;
  logic [PCT_W-1:0]  percent;
  logic              low_event;

  gauge_scoreboard sb = new();
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int quiet_cycles  = 0;

  battery_voltage_monitor_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .now_ms    (now_ms),
    .pin_mv    (pin_mv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_mv   (cell_mv),
    .plausible (plausible),
    .percent   (percent),
    .low_event (low_event)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    reading_t got;
    if (!rst && out_valid && !out_stall) begin
      got.cell_mv   = cell_mv;
      got.plausible = plausible;
      got.percent   = percent;
      got.low_event = low_event;
      sb.check_reading(got);
    end
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the beat
  task send_beat(input logic [TIME_W-1:0] t, input logic [PIN_W-1:0] pin);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= t;
    pin_mv   <= pin;
    do @(posedge clk); while (in_stall);
    sb.take_sample(t, pin);
  endtask

  task set_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx <= REG_REARM) begin
      case (idx)
        REG_INTERVAL: want = val;
        REG_REARM:    want = val & 32'h3FF;
        default:      want = val & 32'h1FFF;
      endcase
      psel <= 1'b1;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== want)
        sb.report($sformatf("reg %0d read %0h want %0h", idx, prdata, want));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // sometimes dropped beats, then a round (sometimes cut short) aimed at a chosen cell voltage or of random pins
  task automatic send_round();
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] room;
    logic [PIN_W-1:0]  pins [16];
    int                target;
    int                base;
    int                lim;
    int                d;
    int                n;
    int                k;
    bit                noisy_pins;
    if (!sb.in_round && sb.interval != 0 && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        t = sb.round_start + (($urandom_range(0, 1) == 1) ? sb.interval - 1 :
                              $urandom_range(0, sb.interval - 1));
        send_beat(t, PIN_W'($urandom_range(0, 4095)));
      end
    end
    noisy_pins = 0;
    target     = 0;
    case ($urandom_range(0, 9))
      0: target = KNEE_MV[$urandom_range(0, 11)];
      1: target = KNEE_MV[$urandom_range(0, 11)] + $urandom_range(0, 8) - 4;
      2: target = sb.low_thr + $urandom_range(0, 4) - 2;
      3: target = sb.low_thr + sb.margin + $urandom_range(0, 4) - 2;
      4: target = ($urandom_range(0, 1) ? sb.win_min : sb.win_max) + $urandom_range(0, 4) - 2;
      5, 6: target = $urandom_range(2900, 4300);
      7: target = $urandom_range(0, 8190);
      8: target = $urandom_range(0, 1) ? 0 : 8190;
      default: noisy_pins = 1;
    endcase
    if (target < 0) target = 0;
    if (target > 8190) target = 8190;
    base = target / 2;
    lim  = base;
    if (4095 - base < lim) lim = 4095 - base;
    if (lim > 300) lim = 300;
    for (k = 0; k < 16; k += 2) begin
      d         = $urandom_range(0, lim);
      pins[k]   = PIN_W'(base + d);
      pins[k+1] = PIN_W'(base - d);
    end
    if (base <= 4080) pins[15] = pins[15] + PIN_W'($urandom_range(0, 15));
    if (noisy_pins) begin
      for (k = 0; k < 16; k++) pins[k] = PIN_W'($urandom_range(0, 4095));
    end
    room = ~sb.interval;
    t = sb.round_start + sb.interval +
        (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, (room > 400) ? 400 : room));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
    for (k = 0; k < n; k++) begin
      send_beat(t, pins[k]);
      t = ($urandom_range(0, 7) == 0) ? $urandom() : t + $urandom_range(0, 40);
    end
  endtask

  task run_phase(input int snd, input int rcv);
    int unsigned goal;
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    goal = sb.used + PHASE_ITEMS;
    while (sb.used < goal) send_round();
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before the first interval: dropped; exactly at it: opens a full-scale round
    send_beat(32'd0, 12'd0);
    send_beat(32'd4999, 12'hFFF);
    send_beat(32'd5000, 12'hFFF);
    repeat (15) send_beat(32'hFFFF_FFFF, 12'hFFF);
    settle();
    run_phase(0, 0);

    set_reg(REG_INTERVAL, 32'd0);
    set_reg(REG_PLAUS_MIN, 32'd0);
    set_reg(REG_PLAUS_MAX, 32'd8190);
    set_reg(REG_LOW_THR, 32'd8190);
    set_reg(REG_REARM, 32'd0);
    run_phase(57, 0);

    set_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    set_reg(REG_PLAUS_MIN, 32'd8190);
    set_reg(REG_PLAUS_MAX, 32'd0);
    set_reg(REG_LOW_THR, 32'd0);
    set_reg(REG_REARM, 32'd1023);
    run_phase(0, 57);

    set_reg(REG_INTERVAL, 32'd1);
    set_reg(REG_PLAUS_MIN, 32'd3000);
    set_reg(REG_PLAUS_MAX, 32'd4200);
    set_reg(REG_LOW_THR, 32'd3700);
    set_reg(REG_REARM, 32'd50);
    set_reg(REG_SPARE, $urandom());
    run_phase(24, 24);

    set_reg(REG_INTERVAL, 32'd1000);
    set_reg(REG_PLAUS_MIN, DATA_W'(RST_PLAUS_MIN));
    set_reg(REG_PLAUS_MAX, DATA_W'(RST_PLAUS_MAX));
    set_reg(REG_LOW_THR, DATA_W'(RST_LOW_THR));
    set_reg(REG_REARM, DATA_W'(RST_REARM));
    run_phase(0, 0);

    set_reg(REG_INTERVAL, $urandom());
    set_reg(REG_PLAUS_MIN, $urandom_range(2000, 3200));
    set_reg(REG_PLAUS_MAX, $urandom_range(3800, 5000));
    set_reg(REG_LOW_THR, $urandom_range(3000, 4000));
    set_reg(REG_REARM, $urandom_range(0, 1023));
    run_phase(57, 0);

    // single-point window just under the threshold
    set_reg(REG_INTERVAL, 32'd7);
    set_reg(REG_PLAUS_MIN, 32'd3600);
    set_reg(REG_PLAUS_MAX, 32'd3600);
    set_reg(REG_LOW_THR, 32'd3601);
    set_reg(REG_REARM, 32'd1023);
    run_phase(0, 57);

    set_reg(REG_INTERVAL, RST_INTERVAL);
    set_reg(REG_PLAUS_MIN, DATA_W'(RST_PLAUS_MIN));
    set_reg(REG_PLAUS_MAX, DATA_W'(RST_PLAUS_MAX));
    set_reg(REG_LOW_THR, DATA_W'(RST_LOW_THR));
    set_reg(REG_REARM, DATA_W'(RST_REARM));
    run_phase(24, 24);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
